### sv/kab_pkg.sv
// Shared types, constants and the update microprogram of the angle/bias Kalman filter.
`default_nettype none
package kab_pkg;

	localparam int WORD_W = 32;
	localparam int FRAC_W = 16;
	localparam int NOISE_W = 23;
	localparam int PERIOD_W = 17;
	localparam int CFG_IDX_W = 3;
	localparam int GYRO_W = 16;
	localparam int DIV_STEPS = WORD_W + FRAC_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(29);

	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = CFG_IDX_W'(3);

	localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST = NOISE_W'(32768);
	localparam logic [NOISE_W-1:0] BIAS_NOISE_RST = NOISE_W'(163840);
	localparam logic [NOISE_W-1:0] MEAS_NOISE_RST = NOISE_W'(491520);
	localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(328);
	localparam logic signed [WORD_W-1:0] ONE = WORD_W'(1) << FRAC_W;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIV, ST_FIN} state_t;
	typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;
	typedef enum logic [4:0] {
		R_ANGLE, R_BIAS, R_C00, R_C01, R_C10, R_C11, R_G, R_MEAS, R_TMP, R_D1,
		R_ERR, R_E, R_K0, R_K1, R_M, R_DT, R_QA, R_QG, R_RM, R_ZERO
	} reg_t;

	typedef struct packed {
		op_t op;
		reg_t sa;
		reg_t sb;
		reg_t dst;
	} uop_t;

	// divider request
	typedef struct packed {
		logic start;
		logic signed [WORD_W-1:0] num;
		logic signed [WORD_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic signed [WORD_W-1:0] quo;
	} div_rsp_t;

	function automatic uop_t uop(input logic [STEP_W-1:0] s);
		uop_t u;
		u = '{OP_ADD, R_ZERO, R_ZERO, R_TMP};
		unique case (s)
			5'd0: u = '{OP_SUB, R_G, R_BIAS, R_TMP};
			5'd1: u = '{OP_MUL, R_TMP, R_DT, R_M};
			5'd2: u = '{OP_ADD, R_ANGLE, R_M, R_ANGLE};
			5'd3: u = '{OP_SUB, R_QA, R_C01, R_TMP};
			5'd4: u = '{OP_SUB, R_TMP, R_C10, R_TMP};
			5'd5: u = '{OP_SUB, R_ZERO, R_C11, R_D1};
			5'd6: u = '{OP_MUL, R_TMP, R_DT, R_M};
			5'd7: u = '{OP_ADD, R_C00, R_M, R_C00};
			5'd8: u = '{OP_MUL, R_D1, R_DT, R_M};
			5'd9: u = '{OP_ADD, R_C01, R_M, R_C01};
			5'd10: u = '{OP_ADD, R_C10, R_M, R_C10};
			5'd11: u = '{OP_MUL, R_QG, R_DT, R_M};
			5'd12: u = '{OP_ADD, R_C11, R_M, R_C11};
			5'd13: u = '{OP_SUB, R_MEAS, R_ANGLE, R_ERR};
			5'd14: u = '{OP_ADD, R_RM, R_C00, R_E};
			5'd15: u = '{OP_DIV, R_C00, R_E, R_K0};
			5'd16: u = '{OP_DIV, R_C10, R_E, R_K1};
			// covariance correction uses the old c00/c01, so update in reverse
			5'd17: u = '{OP_MUL, R_K1, R_C01, R_M};
			5'd18: u = '{OP_SUB, R_C11, R_M, R_C11};
			5'd19: u = '{OP_MUL, R_K1, R_C00, R_M};
			5'd20: u = '{OP_SUB, R_C10, R_M, R_C10};
			5'd21: u = '{OP_MUL, R_K0, R_C01, R_M};
			5'd22: u = '{OP_SUB, R_C01, R_M, R_C01};
			5'd23: u = '{OP_MUL, R_K0, R_C00, R_M};
			5'd24: u = '{OP_SUB, R_C00, R_M, R_C00};
			5'd25: u = '{OP_MUL, R_K0, R_ERR, R_M};
			5'd26: u = '{OP_ADD, R_ANGLE, R_M, R_ANGLE};
			5'd27: u = '{OP_MUL, R_K1, R_ERR, R_M};
			5'd28: u = '{OP_ADD, R_BIAS, R_M, R_BIAS};
			5'd29: u = '{OP_SUB, R_G, R_BIAS, R_TMP};
			default: u = '{OP_ADD, R_ZERO, R_ZERO, R_TMP};
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

### sv/kab_div.sv
// Bit-serial signed fixed-point divider, one quotient bit per cycle, saturating.
`default_nettype none
module kab_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire kab_pkg::div_req_t req,
	output kab_pkg::div_rsp_t rsp
);
	localparam int W = kab_pkg::WORD_W;
	localparam int DW = kab_pkg::DIV_STEPS;

	logic busy_q;
	logic neg_q;
	logic [kab_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] den_q;
	logic [DW-1:0] dvd_q;
	logic [DW-1:0] acc_q;
	logic done_q;
	logic signed [W-1:0] quo_q;

	logic [W:0] trial;
	logic ge;
	logic [W:0] diff;
	logic [DW-1:0] acc_nx;
	logic [DW-1:0] lim;
	logic [DW-1:0] qsat;
	logic [W-1:0] un;
	logic [W-1:0] ud;

	always_comb begin
		trial = {rem_q, dvd_q[DW-1]};
		ge = trial >= {1'b0, den_q};
		diff = trial - {1'b0, den_q};
		acc_nx = {acc_q[DW-2:0], ge};
		lim = neg_q ? (DW'(1) << (W - 1)) : ((DW'(1) << (W - 1)) - DW'(1));
		qsat = (acc_nx > lim) ? lim : acc_nx;
		un = req.num[W-1] ? W'(-req.num) : W'(req.num);
		ud = req.den[W-1] ? W'(-req.den) : W'(req.den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == kab_pkg::DIV_CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.num[W-1] ^ req.den[W-1];
			dvd_q <= {un, kab_pkg::FRAC_W'(0)};
			den_q <= ud;
			rem_q <= '0;
			acc_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			acc_q <= acc_nx;
			if (cnt_q == kab_pkg::DIV_CNT_W'(DW - 1)) begin
				// zero divisor gives a zero gain
				if (den_q == '0)
					quo_q <= '0;
				else if (neg_q)
					quo_q <= -$signed(qsat[W-1:0]);
				else
					quo_q <= $signed(qsat[W-1:0]);
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

endmodule
`default_nettype wire

### sv/kalman_angle_bias_filter.sv
// Top level: two-state angle/gyro-bias Kalman filter on a shared ALU with a microprogram sequencer.
// Usage:
//   Input channel (in_valid/in_stall) carries angle_meas (signed Q16.16) and
//   gyro_rate (signed integer deg/s). A request is taken when in_valid is high
//   and in_stall low. Each request yields one result on the output channel
//   (out_valid/out_stall): angle_est and rate_est, both signed Q16.16.
//   The update runs as 30 micro-ops on one adder/multiplier/saturator. The two
//   gain divisions go to a bit-serial divider; the sequencer waits for each
//   quotient, and the divider takes most of the update time. in_stall stays
//   high until the result is loaded into the output register, so a new request
//   is not taken before the last one is through.
//   Results sit in an output register: the next request is accepted while a
//   result waits; a finished update waits if the output register is still full
//   and out_stall is high.
//   Configuration writes (cfg_we, cfg_index, cfg_data) are registered directly
//   and are to be made only while the filter is idle. Unknown indexes are ignored.
//   Reset (arst_n low) restores default noises and period, clears angle and
//   bias and sets the covariance to identity.
`default_nettype none
module kalman_angle_bias_filter (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [31:0] angle_meas,
	input wire logic signed [kab_pkg::GYRO_W-1:0] gyro_rate,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [31:0] angle_est,
	output logic signed [31:0] rate_est,
	input wire logic cfg_we,
	input wire logic [kab_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [kab_pkg::NOISE_W-1:0] cfg_data
);
	localparam int W = kab_pkg::WORD_W;
	localparam int F = kab_pkg::FRAC_W;

	kab_pkg::state_t state_q, state_nx;
	logic [kab_pkg::STEP_W-1:0] step_q;
	logic [kab_pkg::NOISE_W-1:0] qa_q, qg_q, rm_q;
	logic [kab_pkg::PERIOD_W-1:0] dt_q;
	logic signed [W-1:0] angle_q, bias_q, c00_q, c01_q, c10_q, c11_q;
	logic signed [W-1:0] g_q, meas_q, tmp_q, d1_q, err_q, e_q, k0_q, k1_q, m_q;
	logic out_valid_q;
	logic signed [W-1:0] angle_est_q, rate_est_q;

	kab_pkg::uop_t u;
	logic signed [W-1:0] opa, opb, res, wdata;
	logic wr_en;
	logic accept, div_start, load_out;
	kab_pkg::div_req_t dreq;
	kab_pkg::div_rsp_t drsp;

	logic signed [W:0] sum;
	logic [W-1:0] ua, ub;
	logic [2*W-1:0] prod, prod_r;
	logic [2*W-F-1:0] mq, mlim, msat;
	logic mneg;

	function automatic logic signed [W-1:0] rd(input kab_pkg::reg_t r,
			input logic signed [W-1:0] an, bi, p00, p01, p10, p11, gg, me, tm,
			dd, er, ee, kk0, kk1, mm, dt, qa, qg, rm);
		logic signed [W-1:0] v;
		v = '0;
		unique case (r)
			kab_pkg::R_ANGLE: v = an;
			kab_pkg::R_BIAS: v = bi;
			kab_pkg::R_C00: v = p00;
			kab_pkg::R_C01: v = p01;
			kab_pkg::R_C10: v = p10;
			kab_pkg::R_C11: v = p11;
			kab_pkg::R_G: v = gg;
			kab_pkg::R_MEAS: v = me;
			kab_pkg::R_TMP: v = tm;
			kab_pkg::R_D1: v = dd;
			kab_pkg::R_ERR: v = er;
			kab_pkg::R_E: v = ee;
			kab_pkg::R_K0: v = kk0;
			kab_pkg::R_K1: v = kk1;
			kab_pkg::R_M: v = mm;
			kab_pkg::R_DT: v = dt;
			kab_pkg::R_QA: v = qa;
			kab_pkg::R_QG: v = qg;
			kab_pkg::R_RM: v = rm;
			default: v = '0;
		endcase
		return v;
	endfunction

	assign u = kab_pkg::uop(step_q);

	always_comb begin
		opa = rd(u.sa, angle_q, bias_q, c00_q, c01_q, c10_q, c11_q, g_q, meas_q, tmp_q,
			d1_q, err_q, e_q, k0_q, k1_q, m_q, W'(dt_q), W'(qa_q), W'(qg_q), W'(rm_q));
		opb = rd(u.sb, angle_q, bias_q, c00_q, c01_q, c10_q, c11_q, g_q, meas_q, tmp_q,
			d1_q, err_q, e_q, k0_q, k1_q, m_q, W'(dt_q), W'(qa_q), W'(qg_q), W'(rm_q));

		if (u.op == kab_pkg::OP_SUB)
			sum = {opa[W-1], opa} - {opb[W-1], opb};
		else
			sum = {opa[W-1], opa} + {opb[W-1], opb};

		// sign-magnitude product, rounded half away from zero, saturated
		mneg = opa[W-1] ^ opb[W-1];
		ua = opa[W-1] ? W'(-opa) : W'(opa);
		ub = opb[W-1] ? W'(-opb) : W'(opb);
		prod = {{W{1'b0}}, ua} * {{W{1'b0}}, ub};
		prod_r = prod + ((2*W)'(1) << (F - 1));
		mq = prod_r[2*W-1:F];
		mlim = mneg ? ((2*W-F)'(1) << (W - 1)) : (((2*W-F)'(1) << (W - 1)) - (2*W-F)'(1));
		msat = (mq > mlim) ? mlim : mq;

		unique case (u.op)
			kab_pkg::OP_MUL: res = mneg ? -$signed(msat[W-1:0]) : $signed(msat[W-1:0]);
			kab_pkg::OP_DIV: res = drsp.quo;
			default: begin
				if (sum[W] != sum[W-1])
					res = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
				else
					res = sum[W-1:0];
			end
		endcase
	end

	// sequencer
	always_comb begin
		state_nx = state_q;
		accept = 1'b0;
		div_start = 1'b0;
		wr_en = 1'b0;
		load_out = 1'b0;
		wdata = res;
		unique case (state_q)
			kab_pkg::ST_IDLE: begin
				accept = in_valid;
				if (in_valid)
					state_nx = kab_pkg::ST_RUN;
			end
			kab_pkg::ST_RUN: begin
				if (u.op == kab_pkg::OP_DIV) begin
					div_start = 1'b1;
					state_nx = kab_pkg::ST_DIV;
				end else begin
					wr_en = 1'b1;
					if (step_q == kab_pkg::LAST_STEP)
						state_nx = kab_pkg::ST_FIN;
				end
			end
			kab_pkg::ST_DIV: begin
				if (drsp.done) begin
					wr_en = 1'b1;
					state_nx = kab_pkg::ST_RUN;
				end
			end
			kab_pkg::ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_nx = kab_pkg::ST_IDLE;
				end
			end
			default: state_nx = kab_pkg::ST_IDLE;
		endcase
	end

	assign dreq.start = div_start;
	assign dreq.num = opa;
	assign dreq.den = opb;

	kab_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.rsp(drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kab_pkg::ST_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
			qa_q <= kab_pkg::ANGLE_NOISE_RST;
			qg_q <= kab_pkg::BIAS_NOISE_RST;
			rm_q <= kab_pkg::MEAS_NOISE_RST;
			dt_q <= kab_pkg::PERIOD_RST;
			angle_q <= '0;
			bias_q <= '0;
			c00_q <= kab_pkg::ONE;
			c01_q <= '0;
			c10_q <= '0;
			c11_q <= kab_pkg::ONE;
		end else begin
			state_q <= state_nx;
			if (accept)
				step_q <= '0;
			else if (wr_en)
				step_q <= step_q + 1'b1;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					kab_pkg::CFG_ANGLE_NOISE: qa_q <= cfg_data;
					kab_pkg::CFG_BIAS_NOISE: qg_q <= cfg_data;
					kab_pkg::CFG_MEAS_NOISE: rm_q <= cfg_data;
					kab_pkg::CFG_PERIOD: dt_q <= cfg_data[kab_pkg::PERIOD_W-1:0];
					default: ;
				endcase
			end
			if (wr_en) begin
				unique case (u.dst)
					kab_pkg::R_ANGLE: angle_q <= wdata;
					kab_pkg::R_BIAS: bias_q <= wdata;
					kab_pkg::R_C00: c00_q <= wdata;
					kab_pkg::R_C01: c01_q <= wdata;
					kab_pkg::R_C10: c10_q <= wdata;
					kab_pkg::R_C11: c11_q <= wdata;
					default: ;
				endcase
			end
		end
	end

	// scratch and output payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			g_q <= {gyro_rate, F'(0)};
			meas_q <= angle_meas;
		end
		if (wr_en) begin
			unique case (u.dst)
				kab_pkg::R_TMP: tmp_q <= wdata;
				kab_pkg::R_D1: d1_q <= wdata;
				kab_pkg::R_ERR: err_q <= wdata;
				kab_pkg::R_E: e_q <= wdata;
				kab_pkg::R_K0: k0_q <= wdata;
				kab_pkg::R_K1: k1_q <= wdata;
				kab_pkg::R_M: m_q <= wdata;
				default: ;
			endcase
		end
		if (load_out) begin
			angle_est_q <= angle_q;
			rate_est_q <= tmp_q;
		end
	end

	assign in_stall = (state_q != kab_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign angle_est = angle_est_q;
	assign rate_est = rate_est_q;

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (state_q == kab_pkg::ST_DIV))
		else $error("divide issued but sequencer did not wait");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kab_pkg::ST_RUN) |-> (step_q <= kab_pkg::LAST_STEP))
		else $error("microprogram step out of range");

	a_fin_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kab_pkg::ST_FIN && !out_valid_q) |=> out_valid_q)
		else $error("finished update not presented");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> (state_q == kab_pkg::ST_DIV))
		else $error("divider finished outside a divide step");

endmodule
`default_nettype wire

### tb/sv/kab_checker.sv
// Checker for the angle/bias Kalman filter: watches both channels, predicts and compares results.
`default_nettype none
module kab_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic signed [31:0] angle_meas,
	input wire logic signed [kab_pkg::GYRO_W-1:0] gyro_rate,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic signed [31:0] angle_est,
	input wire logic signed [31:0] rate_est,
	input wire logic cfg_we,
	input wire logic [kab_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [kab_pkg::NOISE_W-1:0] cfg_data,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;

	typedef struct packed {
		logic signed [31:0] angle;
		logic signed [31:0] rate;
	} estimate_t;

	estimate_t est_q[$];

	logic [kab_pkg::NOISE_W-1:0] q_angle, q_bias, r_meas;
	logic [kab_pkg::PERIOD_W-1:0] period;
	longint angle_s, bias_s, p00, p01, p10, p11;

	function automatic longint clamp(input longint v);
		if (v > WMAX) return WMAX;
		if (v < WMIN) return WMIN;
		return v;
	endfunction

	// rounded Q16.16 product, ties away from zero
	function automatic longint fmul(input longint a, input longint b);
		bit neg;
		longint unsigned ua, ub, r, lim;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		lim = neg ? 64'd2147483648 : 64'd2147483647;
		r = (ua * ub + 64'd32768) >> kab_pkg::FRAC_W;
		if (r > lim) r = lim;
		return neg ? -longint'(r) : longint'(r);
	endfunction

	// truncated Q16.16 quotient, zero divisor gives zero
	function automatic longint fdiv(input longint n, input longint d);
		bit neg;
		longint unsigned un, ud, q, lim;
		if (d == 0) return 0;
		neg = (n < 0) != (d < 0);
		un = (n < 0) ? -n : n;
		ud = (d < 0) ? -d : d;
		lim = neg ? 64'd2147483648 : 64'd2147483647;
		q = (un << kab_pkg::FRAC_W) / ud;
		if (q > lim) q = lim;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic estimate_t filter_update(input longint meas, input longint g);
		longint dt, d0, d1, err, e, k0, k1, t0, t1;
		estimate_t r;
		dt = longint'(period);
		angle_s = clamp(angle_s + fmul(clamp(g - bias_s), dt));
		d0 = clamp(clamp(longint'(q_angle) - p01) - p10);
		d1 = clamp(-p11);
		p00 = clamp(p00 + fmul(d0, dt));
		p01 = clamp(p01 + fmul(d1, dt));
		p10 = clamp(p10 + fmul(d1, dt));
		p11 = clamp(p11 + fmul(longint'(q_bias), dt));
		err = clamp(meas - angle_s);
		e = clamp(longint'(r_meas) + p00);
		k0 = fdiv(p00, e);
		k1 = fdiv(p10, e);
		t0 = p00;
		t1 = p01;
		p00 = clamp(p00 - fmul(k0, t0));
		p01 = clamp(p01 - fmul(k0, t1));
		p10 = clamp(p10 - fmul(k1, t0));
		p11 = clamp(p11 - fmul(k1, t1));
		angle_s = clamp(angle_s + fmul(k0, err));
		bias_s = clamp(bias_s + fmul(k1, err));
		r.angle = angle_s[31:0];
		r.rate = 32'(clamp(g - bias_s));
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		estimate_t want;
		if (!arst_n) begin
			q_angle = kab_pkg::ANGLE_NOISE_RST;
			q_bias = kab_pkg::BIAS_NOISE_RST;
			r_meas = kab_pkg::MEAS_NOISE_RST;
			period = kab_pkg::PERIOD_RST;
			angle_s = 0;
			bias_s = 0;
			p00 = 65536;
			p01 = 0;
			p10 = 0;
			p11 = 65536;
			est_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					kab_pkg::CFG_ANGLE_NOISE: q_angle = cfg_data;
					kab_pkg::CFG_BIAS_NOISE: q_bias = cfg_data;
					kab_pkg::CFG_MEAS_NOISE: r_meas = cfg_data;
					kab_pkg::CFG_PERIOD: period = cfg_data[kab_pkg::PERIOD_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (est_q.size() == 0) begin
					$display("%0t: result with no request pending: angle %0d rate %0d",
						$time, angle_est, rate_est);
					errors++;
				end else begin
					want = est_q.pop_front();
					if (angle_est !== want.angle) begin
						$display("%0t: angle_est expected %0d actual %0d",
							$time, want.angle, angle_est);
						errors++;
					end
					if (rate_est !== want.rate) begin
						$display("%0t: rate_est expected %0d actual %0d",
							$time, want.rate, rate_est);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				est_q.push_back(filter_update(longint'(angle_meas),
					longint'(gyro_rate) * 65536));
			pending = est_q.size();
		end
	end
endmodule
`default_nettype wire

### tb/sv/tb.sv
// Testbench top: clock, reset, stimulus, configuration phases and the verdict.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN = 300;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [31:0] angle_meas = 0;
	logic signed [kab_pkg::GYRO_W-1:0] gyro_rate = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [31:0] angle_est, rate_est;
	logic cfg_we = 0;
	logic [kab_pkg::CFG_IDX_W-1:0] cfg_index = 0;
	logic [kab_pkg::NOISE_W-1:0] cfg_data = 0;
	int errors, pending;
	int cycles = 0;
	int burst_left = 0;
	int stall_mode = 0;

	always #4 clk = ~clk;

	kalman_angle_bias_filter uut (.*);
	kab_checker chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: stall pattern is chosen anew at random from four modes
	always @(posedge clk) begin
		if (cycles % 400 == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 1) == 1);
			2: out_stall <= ($urandom_range(0, 9) < 8);
			default: out_stall <= ((cycles / 50) % 2 == 1);
		endcase
	end

	task automatic send(input logic signed [31:0] a, input logic signed [15:0] g);
		in_valid <= 1;
		angle_meas <= a;
		gyro_rate <= g;
		// stall is sampled mid-cycle so the accepting edge is seen exactly once
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 6);
			in_valid <= 0;
			repeat ($urandom_range(0, 40)) @(posedge clk);
		end
	endtask

	task automatic reg_write(input logic [kab_pkg::CFG_IDX_W-1:0] idx,
			input logic [kab_pkg::NOISE_W-1:0] d);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic wait_idle();
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic random_items(input int n);
		logic signed [31:0] base;
		base = $urandom_range(0, 180 * 65536) - 90 * 65536;
		repeat (n) begin
			if ($urandom_range(0, 9) < 7) begin
				// plausible tilt track with noise and modest rate
				base = base + $signed($urandom_range(0, 131072)) - 65536;
				send(base + $signed($urandom_range(0, 65536)) - 32768,
					16'($signed($urandom_range(0, 1000)) - 500));
			end else begin
				send($urandom, 16'($urandom));
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes at reset settings
		send(32'sh7FFFFFFF, 16'sh7FFF);
		send(32'sh80000000, 16'sh8000);
		send(0, 0);
		send(32'sh7FFFFFFF, 16'sh8000);
		send(32'sh80000000, 16'sh7FFF);
		send(32'sh00010000, 16'sd1);
		send(32'shFFFF0000, -16'sd1);
		send(0, 16'sh7FFF);
		send(0, 16'sh8000);
		send(32'sh7FFFFFFF, 0);
		send(32'sh80000000, 0);
		send(32'h55555555, 16'h5555);
		send(32'hAAAAAAAA, 16'hAAAA);
		random_items(140);
		wait_idle();

		// noise extremes, an oversized period that truncates to the longest one; out-of-range indexes
		reg_write(kab_pkg::CFG_ANGLE_NOISE, 23'd6553600);
		reg_write(kab_pkg::CFG_BIAS_NOISE, 23'd6553600);
		reg_write(kab_pkg::CFG_MEAS_NOISE, 23'd1);
		reg_write(kab_pkg::CFG_PERIOD, 23'h7FFFFF);
		reg_write(kab_pkg::CFG_IDX_W'(4), 23'd12345);
		reg_write(kab_pkg::CFG_IDX_W'(7), 23'h7FFFFF);
		send(32'sh7FFFFFFF, 16'sh7FFF);
		send(32'sh80000000, 16'sh8000);
		random_items(140);
		wait_idle();

		reg_write(kab_pkg::CFG_ANGLE_NOISE, 23'd0);
		reg_write(kab_pkg::CFG_BIAS_NOISE, 23'd0);
		reg_write(kab_pkg::CFG_MEAS_NOISE, 23'd0);
		reg_write(kab_pkg::CFG_PERIOD, 23'd1);
		random_items(140);
		wait_idle();

		reg_write(kab_pkg::CFG_ANGLE_NOISE, 23'h7FFFFF);
		reg_write(kab_pkg::CFG_BIAS_NOISE, 23'h7FFFFF);
		reg_write(kab_pkg::CFG_MEAS_NOISE, 23'h7FFFFF);
		reg_write(kab_pkg::CFG_PERIOD, 23'd65536);
		send(32'sh7FFFFFFF, 16'sh7FFF);
		send(32'sh80000000, 16'sh8000);
		random_items(140);
		wait_idle();

		reg_write(kab_pkg::CFG_ANGLE_NOISE, 23'd6553600);
		reg_write(kab_pkg::CFG_BIAS_NOISE, 23'd1);
		reg_write(kab_pkg::CFG_MEAS_NOISE, 23'd6553600);
		reg_write(kab_pkg::CFG_PERIOD, 23'd65535);
		random_items(140);
		wait_idle();

		repeat (3) begin
			reg_write(kab_pkg::CFG_ANGLE_NOISE, 23'($urandom_range(0, 6553600)));
			reg_write(kab_pkg::CFG_BIAS_NOISE, 23'($urandom_range(0, 6553600)));
			reg_write(kab_pkg::CFG_MEAS_NOISE, 23'($urandom_range(1, 6553600)));
			reg_write(kab_pkg::CFG_PERIOD, 23'($urandom_range(1, 65536)));
			random_items(140);
			wait_idle();
		end

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
sv/kab_pkg.sv
sv/kab_div.sv
sv/kalman_angle_bias_filter.sv
tb/sv/kab_checker.sv
tb/sv/tb.sv
